// ===== rtl/fwrs_pkg.sv =====
// types and constants shared by the queue with discard stack block
`timescale 1ns / 1ps

package fwrs_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } act_t;

  typedef enum logic [2:0] {
    OP_ENQ      = 3'd0,
    OP_DROP     = 3'd1,
    OP_DEQ_PUSH = 3'd2,
    OP_DEQ_LOSE = 3'd3,
    OP_RECYCLE  = 3'd4,
    OP_UNDER    = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK           = 3'd0,
    STAT_QUEUE_FULL   = 3'd1,
    STAT_UNDERFLOW    = 3'd2,
    STAT_DISCARD_FULL = 3'd3,
    STAT_RECYCLED     = 3'd4
  } stat_t;

  typedef struct packed {
    logic capture;
    logic execute;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic q_empty;
    logic q_full;
    logic s_empty;
    logic s_full;
  } dp_stat_t;

endpackage

// ===== rtl/fwrs_ctrl.sv =====
// controller: handshake sequencing and operation decode
`timescale 1ns / 1ps

module fwrs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_action,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  fwrs_pkg::dp_stat_t stat,
  output fwrs_pkg::dp_cmd_t  cmd
);

  fwrs_pkg::state_t state_r, state_nxt;
  fwrs_pkg::act_t   action_r, action_nxt;
  fwrs_pkg::op_t    op;
  logic             in_acc;

  assign in_tready  = (state_r == fwrs_pkg::ST_IDLE);
  assign out_tvalid = (state_r == fwrs_pkg::ST_OUT);
  assign in_acc     = in_tvalid & in_tready;

  always_comb begin
    state_nxt  = state_r;
    action_nxt = action_r;
    case (state_r)
      fwrs_pkg::ST_IDLE: begin
        if (in_acc) begin
          action_nxt = fwrs_pkg::act_t'(in_action);
          state_nxt  = fwrs_pkg::ST_EXEC;
        end
      end
      fwrs_pkg::ST_EXEC: begin
        state_nxt = fwrs_pkg::ST_OUT;
      end
      fwrs_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = fwrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fwrs_pkg::ST_IDLE;
      end
    endcase
  end

  // pick the operation from the latched action and the occupancy flags
  always_comb begin
    case (action_r)
      fwrs_pkg::ACT_ENQUEUE: begin
        op = stat.q_full ? fwrs_pkg::OP_DROP : fwrs_pkg::OP_ENQ;
      end
      fwrs_pkg::ACT_DEQUEUE: begin
        if (!stat.q_empty) begin
          op = stat.s_full ? fwrs_pkg::OP_DEQ_LOSE : fwrs_pkg::OP_DEQ_PUSH;
        end else if (!stat.s_empty) begin
          op = fwrs_pkg::OP_RECYCLE;
        end else begin
          op = fwrs_pkg::OP_UNDER;
        end
      end
      default: begin
        op = fwrs_pkg::OP_UNDER;
      end
    endcase
  end

  assign cmd.capture = in_acc;
  assign cmd.execute = (state_r == fwrs_pkg::ST_EXEC);
  assign cmd.op      = op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fwrs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
  end

endmodule

// ===== rtl/fwrs_dp.sv =====
// datapath: queue ring buffer, discard stack, pointers, counts and result register
`timescale 1ns / 1ps

module fwrs_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int STACK_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fwrs_pkg::dp_cmd_t                   cmd,
  output fwrs_pkg::dp_stat_t                  stat,
  input  logic [fwrs_pkg::VALUE_W-1:0]        in_value,
  output logic [fwrs_pkg::STAT_W-1:0]         out_status,
  output logic [fwrs_pkg::VALUE_W-1:0]        out_value,
  output logic [fwrs_pkg::COUNT_W-1:0]        out_qcount,
  output logic [fwrs_pkg::COUNT_W-1:0]        out_scount
);

  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SCNT_W = $clog2(STACK_DEPTH + 1);

  logic [fwrs_pkg::VALUE_W-1:0] q_mem [QUEUE_DEPTH];
  logic [fwrs_pkg::VALUE_W-1:0] s_mem [STACK_DEPTH];

  logic [QIDX_W-1:0]            head_r, head_nxt, tail_r, tail_nxt;
  logic [QCNT_W-1:0]            qfill_r, qfill_nxt;
  logic [SCNT_W-1:0]            sfill_r, sfill_nxt;
  logic [fwrs_pkg::VALUE_W-1:0] value_r, q_rd_r, s_rd_r;
  logic [fwrs_pkg::VALUE_W-1:0] res_value_nxt, res_value_r;
  fwrs_pkg::stat_t              res_stat_nxt, res_stat_r;
  logic [SCNT_W-1:0]            s_top;
  logic [QIDX_W-1:0]            head_inc, tail_inc;
  logic                         q_we, s_we;
  logic [fwrs_pkg::VALUE_W-1:0] q_wdata;

  assign s_top    = sfill_r - SCNT_W'(1);
  assign head_inc = (head_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + QIDX_W'(1);
  assign tail_inc = (tail_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QIDX_W'(1);

  assign stat.q_empty = (qfill_r == '0);
  assign stat.q_full  = (qfill_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.s_empty = (sfill_r == '0);
  assign stat.s_full  = (sfill_r == SCNT_W'(STACK_DEPTH));

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    qfill_nxt     = qfill_r;
    sfill_nxt     = sfill_r;
    q_we          = 1'b0;
    s_we          = 1'b0;
    q_wdata       = value_r;
    res_value_nxt = res_value_r;
    res_stat_nxt  = res_stat_r;
    if (cmd.execute) begin
      case (cmd.op)
        fwrs_pkg::OP_ENQ: begin
          q_we          = 1'b1;
          tail_nxt      = tail_inc;
          qfill_nxt     = qfill_r + QCNT_W'(1);
          res_value_nxt = value_r;
          res_stat_nxt  = fwrs_pkg::STAT_OK;
        end
        fwrs_pkg::OP_DROP: begin
          res_value_nxt = value_r;
          res_stat_nxt  = fwrs_pkg::STAT_QUEUE_FULL;
        end
        fwrs_pkg::OP_DEQ_PUSH: begin
          s_we          = 1'b1;
          head_nxt      = head_inc;
          qfill_nxt     = qfill_r - QCNT_W'(1);
          sfill_nxt     = sfill_r + SCNT_W'(1);
          res_value_nxt = q_rd_r;
          res_stat_nxt  = fwrs_pkg::STAT_OK;
        end
        fwrs_pkg::OP_DEQ_LOSE: begin
          head_nxt      = head_inc;
          qfill_nxt     = qfill_r - QCNT_W'(1);
          res_value_nxt = q_rd_r;
          res_stat_nxt  = fwrs_pkg::STAT_DISCARD_FULL;
        end
        fwrs_pkg::OP_RECYCLE: begin
          q_we          = 1'b1;
          q_wdata       = s_rd_r;
          tail_nxt      = tail_inc;
          qfill_nxt     = qfill_r + QCNT_W'(1);
          sfill_nxt     = s_top;
          res_value_nxt = s_rd_r;
          res_stat_nxt  = fwrs_pkg::STAT_RECYCLED;
        end
        default: begin
          res_value_nxt = '0;
          res_stat_nxt  = fwrs_pkg::STAT_UNDERFLOW;
        end
      endcase
    end
  end

  // read ports run every cycle; pointers hold steady from accept to execute
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[tail_r] <= q_wdata;
    end
    q_rd_r <= q_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      s_mem[sfill_r[SIDX_W-1:0]] <= q_rd_r;
    end
    s_rd_r <= s_mem[s_top[SIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      qfill_r <= '0;
      sfill_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      qfill_r <= qfill_nxt;
      sfill_r <= sfill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value_r <= in_value;
    end
    res_value_r <= res_value_nxt;
    res_stat_r  <= res_stat_nxt;
  end

  assign out_status = res_stat_r;
  assign out_value  = res_value_r;
  assign out_qcount = fwrs_pkg::COUNT_W'(qfill_r);
  assign out_scount = fwrs_pkg::COUNT_W'(sfill_r);

endmodule

// ===== rtl/fifo_with_recycle_stack_top.sv =====
// top level of the fifo queue with discard stack
// result: an accepted item passes through the EXEC state and is presented in the OUT state
// one item at a time: the next item is accepted only after the result is taken, so output stalls hold it off
// the EXEC state comes from the registered store read ahead of the update
// reset: clears pointers, counts and control state; store contents are kept
`timescale 1ns / 1ps

module fifo_with_recycle_stack_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [0:0]  in_tuser,   // action[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_value[31:0], queue_count[36:32], stack_count[41:37], zero
  output logic [2:0]  out_tuser   // status[2:0]
);

  fwrs_pkg::dp_cmd_t              cmd;
  fwrs_pkg::dp_stat_t             stat;
  logic [fwrs_pkg::STAT_W-1:0]    res_status;
  logic [fwrs_pkg::VALUE_W-1:0]   res_value;
  logic [fwrs_pkg::COUNT_W-1:0]   res_qcount, res_scount;

  fwrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  fwrs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_value   (in_tdata),
    .out_status (res_status),
    .out_value  (res_value),
    .out_qcount (res_qcount),
    .out_scount (res_scount)
  );

  assign out_tdata = {6'd0, res_scount, res_qcount, res_value};
  assign out_tuser = res_status;

endmodule

// ===== rtl/fwrs_chk.sv =====
// port-level checker for the fifo queue with discard stack, bound to the top level
`timescale 1ns / 1ps

module fwrs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_tvalid)
    else $error("item accepted while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 out_tvalid)
    else $error("result not presented two cycles after accept");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == fwrs_pkg::STAT_UNDERFLOW |->
      out_tdata[31:0] == 32'd0 && out_tdata[36:32] == 5'd0)
    else $error("underflow with a nonzero value or a filled queue");

endmodule

bind fifo_with_recycle_stack_top fwrs_chk u_fwrs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== verif/tb_fifo_with_recycle_stack_top.sv =====
// self-checking testbench for the fifo queue with discard stack, driven and checked over streams
`timescale 1ns / 1ps

module tb_fifo_with_recycle_stack_top;

  localparam int Q_DEPTH      = 16;
  localparam int S_DEPTH      = 16;
  localparam int RAND_ITEMS   = 1200;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_AT     = 800;
  localparam int IDLE_LIMIT   = 2000;
  localparam int END_CYCLES   = 10;

  typedef struct {
    fwrs_pkg::act_t                       act;
    logic [fwrs_pkg::VALUE_W-1:0]         value;
    bit                                   drain;
  } op_item_t;

  typedef struct {
    fwrs_pkg::stat_t                      status;
    logic [fwrs_pkg::VALUE_W-1:0]         value;
    logic [fwrs_pkg::COUNT_W-1:0]         q_cnt;
    logic [fwrs_pkg::COUNT_W-1:0]         s_cnt;
  } step_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // value[31:0]
  logic [0:0]  in_tuser = '0;   // action[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // out_value[31:0], queue_count[36:32], stack_count[41:37], zero
  logic [2:0]  out_tuser;       // status[2:0]

  op_item_t  pending_items[$];
  step_res_t expected_results[$];
  op_item_t  next_item;
  step_res_t got_res;
  step_res_t want_res;

  // shadow of the queue and the discard stack
  logic [fwrs_pkg::VALUE_W-1:0] q_mem[Q_DEPTH];
  logic [fwrs_pkg::VALUE_W-1:0] s_mem[S_DEPTH];
  int q_head = 0;
  int q_tail = 0;
  int q_fill = 0;
  int s_fill = 0;

  int  total_items = 0;
  int  sent_cnt = 0;
  int  rcv_cnt = 0;
  int  err_cnt = 0;
  int  gap_cnt = 0;
  int  stall_cnt = 0;
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;
  int  idle_cycles = 0;
  bit  quiet;

  fifo_with_recycle_stack_top #(
    .QUEUE_DEPTH(Q_DEPTH),
    .STACK_DEPTH(S_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  assign quiet = (sent_cnt + QUIET_TAIL >= total_items);

  function automatic step_res_t queue_step(fwrs_pkg::act_t act,
                                           logic [fwrs_pkg::VALUE_W-1:0] v);
    step_res_t r;
    logic [fwrs_pkg::VALUE_W-1:0] h;
    r.value = v;
    if (act == fwrs_pkg::ACT_ENQUEUE) begin
      if (q_fill >= Q_DEPTH) begin
        r.status = fwrs_pkg::STAT_QUEUE_FULL;
      end else begin
        q_mem[q_tail] = v;
        q_tail = (q_tail + 1) % Q_DEPTH;
        q_fill++;
        r.status = fwrs_pkg::STAT_OK;
      end
    end else if (q_fill > 0) begin
      h = q_mem[q_head];
      q_head = (q_head + 1) % Q_DEPTH;
      q_fill--;
      r.value = h;
      if (s_fill < S_DEPTH) begin
        s_mem[s_fill] = h;
        s_fill++;
        r.status = fwrs_pkg::STAT_OK;
      end else begin
        r.status = fwrs_pkg::STAT_DISCARD_FULL;
      end
    end else if (s_fill > 0) begin
      s_fill--;
      h = s_mem[s_fill];
      q_mem[q_tail] = h;
      q_tail = (q_tail + 1) % Q_DEPTH;
      q_fill++;
      r.value = h;
      r.status = fwrs_pkg::STAT_RECYCLED;
    end else begin
      r.value = '0;
      r.status = fwrs_pkg::STAT_UNDERFLOW;
    end
    r.q_cnt = fwrs_pkg::COUNT_W'(q_fill);
    r.s_cnt = fwrs_pkg::COUNT_W'(s_fill);
    return r;
  endfunction

  function automatic logic [fwrs_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_item(fwrs_pkg::act_t act, logic [fwrs_pkg::VALUE_W-1:0] v,
                                   bit drain);
    op_item_t it;
    it.act = act;
    it.value = v;
    it.drain = drain;
    pending_items.push_back(it);
  endfunction

  // stimulus and end of run
  initial begin
    int bias;
    int seg_len;
    int n;
    // underflow, extremes, recycle, queue full
    add_item(fwrs_pkg::ACT_DEQUEUE, $urandom, 1'b0);
    add_item(fwrs_pkg::ACT_ENQUEUE, 32'h8000_0000, 1'b0);
    add_item(fwrs_pkg::ACT_ENQUEUE, 32'h7fff_ffff, 1'b0);
    add_item(fwrs_pkg::ACT_DEQUEUE, 32'hffff_ffff, 1'b0);
    add_item(fwrs_pkg::ACT_DEQUEUE, 32'h0000_0000, 1'b0);
    add_item(fwrs_pkg::ACT_DEQUEUE, $urandom, 1'b0);
    add_item(fwrs_pkg::ACT_ENQUEUE, 32'h0000_0000, 1'b0);
    add_item(fwrs_pkg::ACT_ENQUEUE, 32'hffff_ffff, 1'b0);
    for (int i = 0; i < 13; i++) add_item(fwrs_pkg::ACT_ENQUEUE, $urandom, 1'b0);
    add_item(fwrs_pkg::ACT_ENQUEUE, 32'haaaa_aaaa, 1'b0);
    add_item(fwrs_pkg::ACT_DEQUEUE, 32'h5555_5555, 1'b0);
    // biased runs fill and drain both stores
    n = 0;
    while (n < RAND_ITEMS) begin
      seg_len = $urandom_range(8, 48);
      bias = $urandom_range(0, 4) * 20 + 10;
      for (int i = 0; i < seg_len && n < RAND_ITEMS; i++) begin
        add_item(($urandom_range(0, 99) < bias) ? fwrs_pkg::ACT_DEQUEUE
                                                : fwrs_pkg::ACT_ENQUEUE,
                 pick_value(), (n == 0) || (n == DRAIN_AT));
        n++;
      end
    end
    total_items = pending_items.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (!(pending_items.size() == 0 && !in_tvalid && rcv_cnt == sent_cnt));
    repeat (END_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(queue_step(fwrs_pkg::act_t'(in_tuser[0]), in_tdata));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() == 0 ||
                     (pending_items[0].drain &&
                      ((in_tvalid && in_tready) || sent_cnt != rcv_cnt))) begin
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          gap_cnt <= $urandom_range(0, 15);
          in_tvalid <= 1'b0;
        end else begin
          next_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= next_item.value;
          in_tuser <= next_item.act;
        end
      end
    end
  end

  // output ready with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && rcv_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_cnt <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      rcv_cnt <= rcv_cnt + 1;
      got_res.status = fwrs_pkg::stat_t'(out_tuser);
      got_res.value = out_tdata[31:0];
      got_res.q_cnt = out_tdata[36:32];
      got_res.s_cnt = out_tdata[41:37];
      if (expected_results.size() == 0) begin
        $error("unexpected result item: status %0d value %h", out_tuser, got_res.value);
        err_cnt++;
      end else begin
        want_res = expected_results.pop_front();
        if (got_res.status !== want_res.status) begin
          $error("status: expected %0d, actual %0d", want_res.status, out_tuser);
          err_cnt++;
        end
        if (got_res.value !== want_res.value) begin
          $error("out_value: expected %h, actual %h", want_res.value, got_res.value);
          err_cnt++;
        end
        if (got_res.q_cnt !== want_res.q_cnt) begin
          $error("queue_count: expected %0d, actual %0d", want_res.q_cnt, got_res.q_cnt);
          err_cnt++;
        end
        if (got_res.s_cnt !== want_res.s_cnt) begin
          $error("stack_count: expected %0d, actual %0d", want_res.s_cnt, got_res.s_cnt);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any input or output transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
